// File: rtl/cpws_pkg.sv
// Shared types and constants of the capture-period-to-wind-speed block.
package cpws_pkg;

    localparam int NUM_W     = 40;
    localparam int CAP_W     = 16;
    localparam int PTK_W     = 32;
    localparam int DIV_STEPS = NUM_W;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    localparam logic [NUM_W-1:0] NUM_RESET = 40'd4915200000;

    localparam logic REQ_TICK    = 1'b0;
    localparam logic REQ_CAPTURE = 1'b1;

    localparam int APB_DW = 64;
    localparam int APB_AW = 4;
    localparam logic REG_SPEED_NUM = 1'b0;

    typedef struct packed {
        logic tick;
        logic capture;
        logic div_step;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic cap_bad;
        logic div_last;
    } t_status;

endpackage

// File: rtl/cpws_ifs.sv
// Valid/ready channel interfaces for input and result words.
interface cpws_in_if;
    logic                        valid;
    logic                        ready;
    logic                        req_type;
    logic [cpws_pkg::CAP_W-1:0]  capture_value;

    modport source (output valid, output req_type, output capture_value, input ready);
    modport sink   (input valid, input req_type, input capture_value, output ready);
endinterface

interface cpws_out_if;
    logic                        valid;
    logic                        ready;
    logic [cpws_pkg::NUM_W-1:0]  speed_q8;
    logic [cpws_pkg::PTK_W-1:0]  period_ticks;
    logic                        bad_period;

    modport source (output valid, output speed_q8, output period_ticks, output bad_period,
                    input ready);
    modport sink   (input valid, input speed_q8, input period_ticks, input bad_period,
                    output ready);
endinterface

// File: rtl/cpws_ctrl.sv
// Controller state machine: accepts words, sequences the divider, loads the result.
module cpws_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_req_type,
    output logic              o_in_ready,
    input  logic              i_out_ready,
    output logic              o_out_valid,
    input  cpws_pkg::t_status i_status,
    output cpws_pkg::t_cmd    o_cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_WAIT = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;
    logic       in_acc;
    logic       out_free;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign in_acc      = i_in_valid && o_in_ready;
    assign out_free    = !r_out_valid || i_out_ready;

    always_comb begin
        n_state        = r_state;
        o_cmd.tick     = 1'b0;
        o_cmd.capture  = 1'b0;
        o_cmd.div_step = 1'b0;
        o_cmd.load_out = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    if (i_req_type == cpws_pkg::REQ_CAPTURE) begin
                        o_cmd.capture = 1'b1;
                        n_state = i_status.cap_bad ? ST_WAIT : ST_DIV;
                    end else begin
                        o_cmd.tick = 1'b1;
                    end
                end
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_last) begin
                    n_state = ST_WAIT;
                end
            end
            ST_WAIT: begin
                if (out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

// File: rtl/cpws_dp.sv
// Datapath: overflow count, last capture, period, restoring divider, result register.
module cpws_dp #(
    parameter int COUNTER_BITS  = 16,
    parameter int OVERFLOW_BITS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  cpws_pkg::t_cmd               i_cmd,
    input  logic [cpws_pkg::CAP_W-1:0]   i_capture_value,
    input  logic [cpws_pkg::NUM_W-1:0]   i_speed_num,
    output cpws_pkg::t_status            o_status,
    output logic [cpws_pkg::NUM_W-1:0]   o_speed_q8,
    output logic [cpws_pkg::PTK_W-1:0]   o_period_ticks,
    output logic                         o_bad_period
);

    localparam int PW = COUNTER_BITS + OVERFLOW_BITS;

    logic [OVERFLOW_BITS-1:0]         r_ovf;
    logic [COUNTER_BITS-1:0]          r_last;
    logic [PW-1:0]                    r_period;
    logic                             r_bad;
    logic [PW-1:0]                    r_rem;
    logic [cpws_pkg::NUM_W-1:0]       r_quo;
    logic [cpws_pkg::STEP_W-1:0]      r_step;
    logic [cpws_pkg::NUM_W-1:0]       r_speed;
    logic [cpws_pkg::PTK_W-1:0]       r_ptk;
    logic                             r_out_bad;

    logic [31:0]                      cap_ext;
    logic [COUNTER_BITS-1:0]          cap_m;
    logic [PW-1:0]                    period_now;
    logic                             bad_now;
    logic [PW:0]                      trial;
    logic [PW:0]                      diff;
    logic                             fits;
    logic [63:0]                      period64;
    logic [cpws_pkg::PTK_W-1:0]       period_sat;

    // Capture value masked (or widened) to the counter width.
    assign cap_ext    = 32'(i_capture_value);
    assign cap_m      = cap_ext[COUNTER_BITS-1:0];
    assign period_now = {r_ovf, cap_m} - PW'(r_last);
    assign bad_now    = (r_ovf == '0) && (cap_m <= r_last);

    // One restoring step: shift in the next dividend bit, subtract if it fits.
    assign trial = {r_rem, r_quo[cpws_pkg::NUM_W-1]};
    assign diff  = trial - {1'b0, r_period};
    assign fits  = (trial >= {1'b0, r_period});

    assign period64   = 64'(r_period);
    assign period_sat = (period64[63:32] != '0) ? '1 : period64[31:0];

    assign o_status.cap_bad  = bad_now;
    assign o_status.div_last = (r_step == cpws_pkg::STEP_W'(cpws_pkg::DIV_STEPS - 1));

    assign o_speed_q8     = r_speed;
    assign o_period_ticks = r_ptk;
    assign o_bad_period   = r_out_bad;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovf  <= '0;
            r_last <= '0;
        end else if (i_cmd.capture) begin
            r_ovf  <= '0;
            r_last <= cap_m;
        end else if (i_cmd.tick && (r_ovf != '1)) begin
            r_ovf  <= r_ovf + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_period <= period_now;
            r_bad    <= bad_now;
            r_rem    <= '0;
            r_quo    <= i_speed_num;
            r_step   <= '0;
        end else if (i_cmd.div_step) begin
            r_rem    <= fits ? diff[PW-1:0] : trial[PW-1:0];
            r_quo    <= {r_quo[cpws_pkg::NUM_W-2:0], fits};
            r_step   <= r_step + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_speed   <= r_bad ? '0 : r_quo;
            r_ptk     <= r_bad ? '0 : period_sat;
            r_out_bad <= r_bad;
        end
    end

endmodule

// File: rtl/capture_period_to_wind_speed.sv
// Top level of the anemometer capture-period-to-wind-speed block.
// Each input word is either an overflow tick (req_type 0), which bumps a saturating
// overflow count and gives no result, or a capture (req_type 1), which measures the
// period since the previous capture as capture + overflow * 2^COUNTER_BITS - last capture
// and gives one result word: speed_q8 = speed_numerator / period (truncated, 8 fraction
// bits), the period saturated to 32 bits, and bad_period when the period was zero or
// negative, in which case speed and period read 0. A tick is taken and leaves the input
// open. A capture with a good period is accepted, runs forty steps of a one-bit-per-cycle
// restoring divider (the 40-bit quotient sets this count) and loads the result register,
// with the input closed until the load. A capture with a bad period skips the divider
// and goes straight to the load. The load waits, and the input stays closed, for as
// long as an earlier result still sits unaccepted in the result register. That register
// lets ticks and the next capture be accepted while a finished result still waits on
// the output. speed_numerator sits at APB address 0 (64-bit data, low 40 bits used) and
// should be written only while the block is idle.
module capture_period_to_wind_speed #(
    parameter int COUNTER_BITS  = 16,
    parameter int OVERFLOW_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    cpws_in_if.sink                       i_in_word,
    cpws_out_if.source                    o_out_word,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [cpws_pkg::APB_AW-1:0]   paddr,
    input  logic [cpws_pkg::APB_DW-1:0]   pwdata,
    output logic [cpws_pkg::APB_DW-1:0]   prdata,
    output logic                          pready
);

    logic [cpws_pkg::NUM_W-1:0] r_speed_num;
    logic                       cfg_wr;
    logic                       reg_sel;
    cpws_pkg::t_cmd             cmd;
    cpws_pkg::t_status          status;

    // Register index is address bit 3; only the numerator register exists.
    assign reg_sel = paddr[3];
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign prdata  = (reg_sel == cpws_pkg::REG_SPEED_NUM)
                   ? cpws_pkg::APB_DW'(r_speed_num) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_speed_num <= cpws_pkg::NUM_RESET;
        end else if (cfg_wr && (reg_sel == cpws_pkg::REG_SPEED_NUM)) begin
            r_speed_num <= pwdata[cpws_pkg::NUM_W-1:0];
        end
    end

    // The controller owns the handshakes; the datapath owns all arithmetic and the measurement state.
    cpws_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_word.valid),
        .i_req_type  (i_in_word.req_type),
        .o_in_ready  (i_in_word.ready),
        .i_out_ready (o_out_word.ready),
        .o_out_valid (o_out_word.valid),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    cpws_dp #(
        .COUNTER_BITS  (COUNTER_BITS),
        .OVERFLOW_BITS (OVERFLOW_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_capture_value (i_in_word.capture_value),
        .i_speed_num     (r_speed_num),
        .o_status        (status),
        .o_speed_q8      (o_out_word.speed_q8),
        .o_period_ticks  (o_out_word.period_ticks),
        .o_bad_period    (o_out_word.bad_period)
    );

endmodule

// File: rtl/cpws_checker.sv
// Port-level checker for the wind speed block, bound to the top level.
module cpws_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        i_in_ready,
    input logic                        i_req_type,
    input logic                        i_out_valid,
    input logic                        i_out_ready,
    input logic [cpws_pkg::NUM_W-1:0]  i_speed_q8,
    input logic [cpws_pkg::PTK_W-1:0]  i_period_ticks,
    input logic                        i_bad_period
);

    a_bad_zeroes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_bad_period) |-> (i_speed_q8 == '0 && i_period_ticks == '0))
        else $error("bad period word carries nonzero speed or period");

    a_good_period: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_bad_period) |-> (i_period_ticks != '0))
        else $error("valid period word has zero period");

    a_busy_after_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready && i_req_type == cpws_pkg::REQ_CAPTURE) |=> !i_in_ready)
        else $error("input taken again right after a capture");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
        (i_out_valid && $stable(i_speed_q8) && $stable(i_period_ticks)
         && $stable(i_bad_period)))
        else $error("stalled result word changed");

endmodule

bind capture_period_to_wind_speed cpws_checker u_cpws_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_word.valid),
    .i_in_ready     (i_in_word.ready),
    .i_req_type     (i_in_word.req_type),
    .i_out_valid    (o_out_word.valid),
    .i_out_ready    (o_out_word.ready),
    .i_speed_q8     (o_out_word.speed_q8),
    .i_period_ticks (o_out_word.period_ticks),
    .i_bad_period   (o_out_word.bad_period)
);

// File: verif/tb_top.sv
// Self-checking testbench for the capture-period-to-wind-speed block.
`timescale 1ns / 100ps

module tb_top;

    // Overflow count width of the instance under test (the block's default).
    localparam int OVF_W = 16;

    localparam int CLK_HALF      = 10;
    localparam int RESET_CYCLES  = 6;
    // Settling after the last result; longer than one capture holds the input.
    localparam int SETTLE_CYCLES = 60;
    // Length of the long receiver hold-off that backs the block up.
    localparam int LONG_HOLD     = 400;
    // Cycles without any accepted word, APB access or reset before the run is aborted.
    localparam int IDLE_LIMIT    = 5000;
    // A run of overflow ticks that spans many counter wraps.
    localparam int LONG_TICKS    = 40;

    localparam logic [cpws_pkg::APB_AW-1:0] ADDR_SPEED_NUM = {cpws_pkg::REG_SPEED_NUM, 3'b000};
    // First address past the register list; writes there must not land anywhere.
    localparam logic [cpws_pkg::APB_AW-1:0] ADDR_UNMAPPED  = 4'h8;
    localparam logic [cpws_pkg::NUM_W-1:0]  NUM_MAX        = '1;

    typedef struct packed {
        logic                       req_type;
        logic [cpws_pkg::CAP_W-1:0] capture_value;
    } t_in_word;

    typedef struct packed {
        logic [cpws_pkg::NUM_W-1:0] speed_q8;
        logic [cpws_pkg::PTK_W-1:0] period_ticks;
        logic                       bad_period;
    } t_speed_word;

    logic                        clk;
    logic                        rst_n;
    logic                        psel;
    logic                        penable;
    logic                        pwrite;
    logic [cpws_pkg::APB_AW-1:0] paddr;
    logic [cpws_pkg::APB_DW-1:0] pwdata;
    logic [cpws_pkg::APB_DW-1:0] prdata;
    logic                        pready;

    cpws_in_if  in_ch ();
    cpws_out_if out_ch ();

    capture_period_to_wind_speed u_top (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_word  (in_ch),
        .o_out_word (out_ch),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    // Words waiting to be offered, and speed results the block still owes us.
    t_in_word    pending_words[$];
    t_speed_word expected_speeds[$];

    // Our own copy of the block's state, advanced on every accepted input word.
    logic [OVF_W-1:0]             ovf_count;
    logic [cpws_pkg::CAP_W-1:0]   last_capture;
    logic [cpws_pkg::NUM_W-1:0]   num_setting = cpws_pkg::NUM_RESET;

    // Last capture value queued by the stimulus, used to aim captures near it.
    logic [cpws_pkg::CAP_W-1:0]   gen_last = '0;

    bit in_fire       = 1'b0;
    bit quiet         = 1'b0;
    int gap_in        = 0;
    int gap_out       = 0;
    int hold_left     = 0;
    int stall_asks    = 0;
    int stalls_served = 0;
    int idle_cycles   = 0;

    int mismatches    = 0;
    int results_seen  = 0;
    int captures_seen = 0;
    int ticks_seen    = 0;
    int bad_seen      = 0;
    int settings_used = 0;

    t_speed_word want_word;
    t_speed_word got_word;

    initial begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // Known levels on the channels before the first falling edge.
    initial begin
        in_ch.valid         = 1'b0;
        in_ch.req_type      = cpws_pkg::REQ_TICK;
        in_ch.capture_value = '0;
        out_ch.ready        = 1'b0;
    end

    // Expected result of one capture, given the state just before it.
    // With no overflow the period is simply the forward distance, and a capture at or
    // below the previous one is a bad period. With overflows the period is always positive.
    function automatic t_speed_word speed_for_capture(
            input logic [cpws_pkg::CAP_W-1:0] cap,
            input logic [OVF_W-1:0]           ovf,
            input logic [cpws_pkg::CAP_W-1:0] last,
            input logic [cpws_pkg::NUM_W-1:0] num);
        logic [63:0] period;
        t_speed_word w;
        if (ovf == '0) begin
            period = (cap > last) ? (64'(cap) - 64'(last)) : 64'd0;
        end else begin
            period = (64'(ovf) << cpws_pkg::CAP_W) - 64'(last) + 64'(cap);
        end
        if (period == 64'd0) begin
            w.speed_q8     = '0;
            w.period_ticks = '0;
            w.bad_period   = 1'b1;
        end else begin
            w.speed_q8     = cpws_pkg::NUM_W'(64'(num) / period);
            // The reported period saturates at 32 bits; the division uses the full value.
            w.period_ticks = (period > 64'hFFFF_FFFF) ? '1 : period[cpws_pkg::PTK_W-1:0];
            w.bad_period   = 1'b0;
        end
        return w;
    endfunction

    task automatic flag_mismatch(input string what, input logic [63:0] want,
                                 input logic [63:0] got);
        mismatches++;
        if (mismatches <= 10) begin
            $display("[%0t] mismatch on %s: expected 0x%0h, got 0x%0h", $time, what, want, got);
        end
    endtask

    // Input driver: a word stays on the channel until it is taken. Between words the
    // sender may idle at random, except in the quiet last phase.
    always @(negedge clk) begin
        if (!rst_n) begin
            in_ch.valid <= 1'b0;
        end else if (in_ch.valid && !in_fire) begin
            // Word still waiting on the block; hold it steady.
        end else if (gap_in > 0) begin
            gap_in = gap_in - 1;
            in_ch.valid <= 1'b0;
        end else if (pending_words.size() == 0) begin
            in_ch.valid <= 1'b0;
        end else if (!quiet && $urandom_range(7, 0) == 0) begin
            gap_in = $urandom_range(6, 0);
            in_ch.valid <= 1'b0;
        end else begin
            in_ch.valid         <= 1'b1;
            in_ch.req_type      <= pending_words[0].req_type;
            in_ch.capture_value <= pending_words[0].capture_value;
            void'(pending_words.pop_front());
        end
    end

    // Result receiver: random short stalls, plus a long hold-off whenever the stimulus
    // asks for one, which lets the block fill up and push back on its input.
    always @(negedge clk) begin
        if (stall_asks != stalls_served) begin
            stalls_served = stalls_served + 1;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            out_ch.ready <= 1'b0;
        end else if (gap_out > 0) begin
            gap_out = gap_out - 1;
            out_ch.ready <= 1'b0;
        end else if (!quiet && $urandom_range(7, 0) == 0) begin
            gap_out = $urandom_range(6, 0);
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= 1'b1;
        end
    end

    // Input monitor: every accepted word advances our copy of the state, and every
    // accepted capture queues the result it must produce.
    always @(posedge clk) begin
        in_fire <= rst_n && in_ch.valid && in_ch.ready;
        if (!rst_n) begin
            ovf_count    = '0;
            last_capture = '0;
        end else if (in_ch.valid && in_ch.ready) begin
            if (in_ch.req_type == cpws_pkg::REQ_TICK) begin
                ticks_seen++;
                // The overflow count sticks at its maximum.
                if (ovf_count != {OVF_W{1'b1}}) begin
                    ovf_count = ovf_count + 1'b1;
                end
            end else begin
                captures_seen++;
                expected_speeds.push_back(speed_for_capture(in_ch.capture_value, ovf_count,
                                                            last_capture, num_setting));
                ovf_count    = '0;
                last_capture = in_ch.capture_value;
            end
        end
    end

    // Output monitor: each accepted result word is checked against the oldest expectation.
    always @(posedge clk) begin
        if (rst_n && out_ch.valid && out_ch.ready) begin
            results_seen++;
            got_word.speed_q8     = out_ch.speed_q8;
            got_word.period_ticks = out_ch.period_ticks;
            got_word.bad_period   = out_ch.bad_period;
            if (got_word.bad_period) begin
                bad_seen++;
            end
            if (expected_speeds.size() == 0) begin
                flag_mismatch("result word with nothing expected (speed_q8)", 64'd0,
                              64'(got_word.speed_q8));
            end else begin
                want_word = expected_speeds.pop_front();
                if (got_word.speed_q8 !== want_word.speed_q8) begin
                    flag_mismatch("speed_q8", 64'(want_word.speed_q8), 64'(got_word.speed_q8));
                end
                if (got_word.period_ticks !== want_word.period_ticks) begin
                    flag_mismatch("period_ticks", 64'(want_word.period_ticks),
                                  64'(got_word.period_ticks));
                end
                if (got_word.bad_period !== want_word.bad_period) begin
                    flag_mismatch("bad_period", 64'(want_word.bad_period),
                                  64'(got_word.bad_period));
                end
            end
        end
    end

    // Watchdog: any accepted word, APB access or reset counts as progress.
    always @(posedge clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || psel || !rst_n) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("[%0t] no progress for %0d cycles, %0d results still owed",
                     $time, IDLE_LIMIT, expected_speeds.size());
            $display("FAILURE");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // APB write: setup cycle, then access cycle until pready is seen at a rising edge.
    task automatic apb_write(input logic [cpws_pkg::APB_AW-1:0] addr,
                             input logic [cpws_pkg::APB_DW-1:0] data);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = addr;
        pwdata  = data;
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic apb_read(input logic [cpws_pkg::APB_AW-1:0] addr,
                            output logic [cpws_pkg::APB_DW-1:0] data);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = addr;
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        data = prdata;
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    // The numerator register must always read back what our copy holds.
    task automatic check_numerator();
        logic [cpws_pkg::APB_DW-1:0] rd;
        apb_read(ADDR_SPEED_NUM, rd);
        if (rd[cpws_pkg::NUM_W-1:0] !== num_setting) begin
            flag_mismatch("speed_numerator readback", 64'(num_setting),
                          64'(rd[cpws_pkg::NUM_W-1:0]));
        end
    endtask

    // The upper data bits carry junk so that only the low 40 bits are shown to matter.
    task automatic set_numerator(input logic [cpws_pkg::NUM_W-1:0] value);
        logic [cpws_pkg::APB_DW-cpws_pkg::NUM_W-1:0] junk;
        junk = (cpws_pkg::APB_DW-cpws_pkg::NUM_W)'($urandom());
        apb_write(ADDR_SPEED_NUM, {junk, value});
        num_setting = value;
        settings_used++;
        check_numerator();
    endtask

    task automatic push_ticks(input int n);
        t_in_word w;
        for (int i = 0; i < n; i++) begin
            w.req_type      = cpws_pkg::REQ_TICK;
            w.capture_value = cpws_pkg::CAP_W'($urandom());
            pending_words.push_back(w);
        end
    endtask

    task automatic push_capture(input logic [cpws_pkg::CAP_W-1:0] cap);
        t_in_word w;
        w.req_type      = cpws_pkg::REQ_CAPTURE;
        w.capture_value = cap;
        pending_words.push_back(w);
        gen_last = cap;
    endtask

    // Block idle: nothing left to send, nothing owed, and a capture's worth of settling.
    task automatic wait_idle();
        while (pending_words.size() != 0 || in_ch.valid || expected_speeds.size() != 0) begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Random traffic shaped like a real anemometer: mostly a capture after a few overflow
    // ticks, with back-to-back captures, long gaps and captures at, just above or just
    // below the previous value mixed in to hit the bad-period and wrap-around paths.
    task automatic run_random(input int count);
        int made;
        int pick;
        int ticks;
        logic [cpws_pkg::CAP_W-1:0] cap;
        made = 0;
        while (made < count) begin
            pick = $urandom_range(99, 0);
            if (pick < 65) begin
                ticks = $urandom_range(3, 0);
            end else if (pick < 89) begin
                ticks = 0;
            end else if (pick < 99) begin
                ticks = $urandom_range(20, 4);
            end else begin
                ticks = $urandom_range(150, 60);
            end
            pick = $urandom_range(99, 0);
            if (pick < 50) begin
                cap = cpws_pkg::CAP_W'($urandom());
            end else if (pick < 65) begin
                cap = gen_last + cpws_pkg::CAP_W'($urandom_range(8, 1));
            end else if (pick < 75) begin
                cap = gen_last;
            end else if (pick < 85) begin
                cap = gen_last - cpws_pkg::CAP_W'($urandom_range(8, 1));
            end else if (pick < 93) begin
                cap = '0;
            end else begin
                cap = '1;
            end
            push_ticks(ticks);
            push_capture(cap);
            made = made + ticks + 1;
        end
    endtask

    initial begin
        rst_n   = 1'b0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // The numerator comes out of reset at its default value.
        check_numerator();

        // Directed part under the reset numerator.
        push_capture('0);           // equal to the reset capture: zero period
        push_capture('1);           // largest plain period
        push_capture('1);           // same capture again: zero period
        push_capture(16'd100);      // below the previous capture: negative period
        push_ticks(1);
        push_capture(16'd50);       // one overflow with a capture below the previous one
        push_ticks(2);
        push_capture('1);
        push_capture(16'd1);        // negative period again
        push_ticks(1);
        push_capture(16'd1);        // exactly one full counter wrap
        push_capture('0);           // negative, leaves the last capture at zero
        // A long run of overflow ticks gives a period spanning many counter wraps.
        push_ticks(LONG_TICKS);
        push_capture('1);
        push_ticks(1);
        push_capture('0);           // period of one tick: speed equals the numerator
        wait_idle();

        // A write past the register list must leave the numerator untouched.
        apb_write(ADDR_UNMAPPED, {$urandom(), $urandom()});
        check_numerator();
        push_capture(16'd200);
        wait_idle();

        // Largest numerator: a one-tick period gives the largest speed.
        set_numerator(NUM_MAX);
        push_capture(gen_last + 1'b1);
        push_capture(gen_last);
        run_random(190);
        wait_idle();

        // Smallest nonzero numerator, with the receiver holding off for a long stretch.
        set_numerator(cpws_pkg::NUM_W'(1));
        push_capture(gen_last + 1'b1);
        run_random(190);
        stall_asks = stall_asks + 1;
        wait_idle();

        // Zero numerator: every speed reads zero.
        set_numerator('0);
        run_random(120);
        wait_idle();

        // Random full-width numerator, with the sender pausing halfway until the
        // block has handed back every result.
        set_numerator(cpws_pkg::NUM_W'({$urandom(), $urandom()}));
        run_random(100);
        wait_idle();
        run_random(100);
        wait_idle();

        // Modest random numerator below 2^24, so speeds span zero up to that numerator.
        set_numerator(cpws_pkg::NUM_W'($urandom_range(32'h00FF_FFFF, 1)));
        run_random(190);
        wait_idle();

        // Last phase at the default numerator with no idling on either side.
        quiet = 1'b1;
        set_numerator(cpws_pkg::NUM_RESET);
        run_random(190);
        wait_idle();

        $display("Covered %0d captures and %0d overflow ticks under %0d numerator settings,",
                 captures_seen, ticks_seen, settings_used);
        $display("including %0d bad periods; %0d results checked, %0d mismatches.",
                 bad_seen, results_seen, mismatches);
        if (mismatches == 0 && expected_speeds.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
